/* src/bmalloc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bmalloc_pkg;

  // Geometry of the bitmap
  localparam int MaxPositions = 1024;
  localparam int WordBits     = 32;
  localparam int MapWords     = (MaxPositions + WordBits - 1) / WordBits;
  localparam int PosW         = $clog2(MaxPositions);
  localparam int LenW         = PosW + 1;
  localparam int OffW         = $clog2(WordBits);
  localparam int WordAddrW    = $clog2(MapWords);

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxPositions);
  localparam logic [LenW-1:0] LenReset = LenW'(1024);

  // Command codes
  localparam logic [1:0] CMD_TEST  = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [PosW-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic [PosW-1:0] result_pos;
    logic            hit;
    logic            all_used;
    logic [LenW-1:0] used_count;
  } out_word_t;

  // Write request into the bitmap store
  typedef struct packed {
    logic                 en;
    logic [WordAddrW-1:0] addr;
    logic [WordBits-1:0]  data;
  } map_wr_t;

  // Outcome of examining one bitmap word
  typedef struct packed {
    logic            found;
    logic [PosW-1:0] pos;
  } scan_res_t;

endpackage
`default_nettype wire

/* src/bmalloc_map.sv */
`timescale 1ns / 1ps
`default_nettype none
module bmalloc_map (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 rd_en_i,
  input  wire logic [bmalloc_pkg::WordAddrW-1:0]    rd_addr_i,
  output logic      [bmalloc_pkg::WordBits-1:0]     rd_data_o,
  input  wire bmalloc_pkg::map_wr_t                 wr_i
);
  import bmalloc_pkg::*;

  logic [WordBits-1:0] mem [MapWords];
  logic [MapWords-1:0] vld_q;
  logic [WordBits-1:0] rd_data_q;

  // Track written words; an unwritten word reads as all clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.addr] <= 1'b1;
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

/* src/bmalloc_scan.sv */
`timescale 1ns / 1ps
`default_nettype none
module bmalloc_scan (
  input  wire logic [bmalloc_pkg::WordBits-1:0]  word_i,
  input  wire logic [bmalloc_pkg::WordAddrW-1:0] word_idx_i,
  input  wire logic                              wrap_i,
  input  wire logic [bmalloc_pkg::PosW-1:0]      start_i,
  input  wire logic [bmalloc_pkg::LenW-1:0]      len_i,
  output bmalloc_pkg::scan_res_t                 res_o
);
  import bmalloc_pkg::*;

  logic [WordBits-1:0] cand;
  logic [PosW-1:0]     bit_pos [WordBits];

  // Mark clear in-range bits on the correct side of the start point
  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      bit_pos[i] = {word_idx_i, OffW'(i)};
      cand[i] = !word_i[i] && ({1'b0, bit_pos[i]} < len_i) &&
                (wrap_i ? (bit_pos[i] < start_i) : (bit_pos[i] >= start_i));
    end
  end

  // Pick the lowest candidate
  always_comb begin
    res_o.found = |cand;
    res_o.pos   = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res_o.pos = bit_pos[i];
      end
    end
  end

endmodule
`default_nettype wire

/* src/bitmap_id_allocator_next_fit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Next-fit ID allocator over a bitmap of up to 1024 positions.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries a command word:
// test a bit, get the next free position from the hint, set or clear a bit.
// Output channel (out_valid_o / out_stall_i / out_data_o) returns one result
// word per command, carrying the position, hit flag, used count and full flag.
// The configuration channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the
// managed length; write it only while no command is in flight.
// One command is worked on at a time; in_stall_o stays high until its result
// is handed to the output register. Test, set and clear go from acceptance to
// the output register in order: word read at the accepting edge, then
// modify/write, then hand-off.
// Get reads one bitmap word per cycle through the single read port, from the
// hint word to the last word, then from word 0 back to the hint word: up to
// 33 reads, fewer when a free bit shows up early.
// A new command is accepted the cycle after the previous result is handed off.
// Reset clears the map at once (per-word valid bits), the hint and count go
// to zero and the length to 1024. A stalled output holds its word; the
// finished result then waits in the sequencer and no new command is taken.
module bitmap_id_allocator_next_fit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire bmalloc_pkg::in_word_t         in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output bmalloc_pkg::out_word_t             out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bmalloc_pkg::LenW-1:0]  cfg_data_i
);
  import bmalloc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [LenW-1:0]      cfg_len_q;
  logic [PosW-1:0]      hint_q, hint_d;
  logic [LenW-1:0]      count_q, count_d;
  logic [1:0]           cmd_q, cmd_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [PosW-1:0]      start_q, start_d;
  logic [WordAddrW-1:0] iss_w_q, iss_w_d;
  logic                 iss_wrap_q, iss_wrap_d;
  logic                 iss_act_q, iss_act_d;
  logic [WordAddrW-1:0] ev_w_q, ev_w_d;
  logic                 ev_wrap_q, ev_wrap_d;
  logic                 ev_vld_q, ev_vld_d;
  out_word_t            res_q, res_d;
  out_word_t            out_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;

  logic                 accept;
  logic [LenW-1:0]      len_eff;
  logic [LenW-1:0]      len_m1;
  logic [WordAddrW-1:0] last_w;
  logic [PosW-1:0]      start_now;
  logic                 rd_en;
  logic [WordAddrW-1:0] rd_addr;
  logic [WordBits-1:0]  rd_data;
  map_wr_t              map_wr;
  scan_res_t            scan_res;
  logic                 in_range;
  logic                 cur_bit;
  logic [LenW-1:0]      pos_inc;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Saturate the configured length and derive scan limits
  assign len_eff   = (cfg_len_q > MaxLen) ? MaxLen : cfg_len_q;
  assign len_m1    = len_eff - LenW'(1);
  assign last_w    = len_m1[PosW-1:OffW];
  assign start_now = ({1'b0, hint_q} < len_eff) ? hint_q : '0;

  // Point-command decode on the read word
  assign in_range = ({1'b0, pos_q} < len_eff);
  assign cur_bit  = rd_data[pos_q[OffW-1:0]];
  assign pos_inc  = {1'b0, pos_q} + LenW'(1);

  // Read port: command word at accept, scan words while issuing
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_en   = accept;
      rd_addr = in_data_i.position[PosW-1:OffW];
    end else begin
      rd_en   = (state_q == S_SCAN) && iss_act_q;
      rd_addr = iss_w_q;
    end
  end

  bmalloc_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (map_wr)
  );

  bmalloc_scan u_scan (
    .word_i     (rd_data),
    .word_idx_i (ev_w_q),
    .wrap_i     (ev_wrap_q),
    .start_i    (start_q),
    .len_i      (len_eff),
    .res_o      (scan_res)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    hint_d     = hint_q;
    count_d    = count_q;
    cmd_d      = cmd_q;
    pos_d      = pos_q;
    start_d    = start_q;
    iss_w_d    = iss_w_q;
    iss_wrap_d = iss_wrap_q;
    iss_act_d  = iss_act_q;
    ev_w_d     = iss_w_q;
    ev_wrap_d  = iss_wrap_q;
    ev_vld_d   = 1'b0;
    res_d      = res_q;
    map_wr     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = in_data_i.cmd;
          pos_d   = in_data_i.position;
          start_d = start_now;
          if (in_data_i.cmd == CMD_GET) begin
            if (len_eff == '0) begin
              res_d.result_pos = '0;
              res_d.hit        = 1'b0;
              res_d.used_count = count_q;
              res_d.all_used   = 1'b1;
              state_d          = S_DONE;
            end else begin
              iss_w_d    = start_now[PosW-1:OffW];
              iss_wrap_d = 1'b0;
              iss_act_d  = 1'b1;
              state_d    = S_SCAN;
            end
          end else begin
            state_d = S_MOD;
          end
        end
      end

      S_MOD: begin
        res_d.result_pos = pos_q;
        res_d.hit        = 1'b0;
        case (cmd_q)
          CMD_TEST: begin
            res_d.hit = in_range && cur_bit;
          end
          CMD_SET: begin
            if (in_range && !cur_bit) begin
              map_wr.en   = 1'b1;
              map_wr.addr = pos_q[PosW-1:OffW];
              map_wr.data = rd_data | (WordBits'(1) << pos_q[OffW-1:0]);
              count_d     = count_q + LenW'(1);
              hint_d      = (pos_inc >= len_eff) ? '0 : pos_inc[PosW-1:0];
              res_d.hit   = 1'b1;
            end
          end
          CMD_CLEAR: begin
            if (in_range && cur_bit) begin
              map_wr.en   = 1'b1;
              map_wr.addr = pos_q[PosW-1:OffW];
              map_wr.data = rd_data & ~(WordBits'(1) << pos_q[OffW-1:0]);
              count_d     = count_q - LenW'(1);
              res_d.hit   = 1'b1;
            end
          end
          default: begin
            res_d.hit = 1'b0;
          end
        endcase
        res_d.used_count = count_d;
        res_d.all_used   = (count_d >= len_eff);
        state_d          = S_DONE;
      end

      S_SCAN: begin
        // Advance the read pointer: hint word to last word, then wrap
        ev_vld_d = iss_act_q;
        if (iss_act_q) begin
          if (!iss_wrap_q) begin
            if (iss_w_q == last_w) begin
              if (start_q == '0) begin
                iss_act_d = 1'b0;
              end else begin
                iss_wrap_d = 1'b1;
                iss_w_d    = '0;
              end
            end else begin
              iss_w_d = iss_w_q + WordAddrW'(1);
            end
          end else if (iss_w_q == start_q[PosW-1:OffW]) begin
            iss_act_d = 1'b0;
          end else begin
            iss_w_d = iss_w_q + WordAddrW'(1);
          end
        end
        // Evaluate the word read last cycle
        res_d.used_count = count_q;
        res_d.all_used   = (count_q >= len_eff);
        if (ev_vld_q && scan_res.found) begin
          res_d.result_pos = scan_res.pos;
          res_d.hit        = 1'b1;
          iss_act_d        = 1'b0;
          ev_vld_d         = 1'b0;
          state_d          = S_DONE;
        end else if (!ev_vld_q && !iss_act_q) begin
          res_d.result_pos = '0;
          res_d.hit        = 1'b0;
          state_d          = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the output word until taken
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_len_q   <= LenReset;
      hint_q      <= '0;
      count_q     <= '0;
      iss_act_q   <= 1'b0;
      ev_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hint_q      <= hint_d;
      count_q     <= count_d;
      iss_act_q   <= iss_act_d;
      ev_vld_q    <= ev_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_len_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    pos_q      <= pos_d;
    start_q    <= start_d;
    iss_w_q    <= iss_w_d;
    iss_wrap_q <= iss_wrap_d;
    ev_w_q     <= ev_w_d;
    ev_wrap_q  <= ev_wrap_d;
    res_q      <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

/* tb/bitmap_alloc_checker.sv */
`timescale 1ns / 1ps
module bitmap_alloc_checker
  import bmalloc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_stall_i,
  input  in_word_t             in_data_i,
  input  wire logic            out_valid_i,
  input  wire logic            out_stall_i,
  input  out_word_t            out_data_i,
  input  wire logic            cfg_valid_i,
  input  wire logic            cfg_ready_i,
  input  wire logic [LenW-1:0] cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   words_checked_o
);

  localparam int PrintLimit = 20;

  // Shadow copy of the allocator state
  logic [MaxPositions-1:0] used_bits;
  logic [PosW-1:0]         alloc_hint;
  logic [LenW-1:0]         used_total;
  logic [LenW-1:0]         length_reg;

  out_word_t               expected_results[$];

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    words_checked_o = 0;
  end

  // Print one line per mismatch (the first few) and count every one
  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count_o < PrintLimit) begin
      $display("MISMATCH %s: got %0d, want %0d (result word %0d, t=%0t)",
               what, got, want, words_checked_o, $realtime);
    end
    fail_count_o++;
  endtask

  // Run one command on the shadow state and return the result word it yields
  function automatic out_word_t alloc_outcome(in_word_t w);
    out_word_t   r;
    int unsigned eff_len;
    int unsigned p;
    int unsigned i;
    logic        in_range;
    logic        found;
    eff_len = (length_reg > MaxLen) ? MaxPositions : length_reg;
    in_range = (w.position < eff_len);
    r.result_pos = w.position;
    r.hit = 1'b0;
    case (w.cmd)
      CMD_TEST: begin
        r.hit = in_range && used_bits[w.position];
      end
      CMD_GET: begin
        // Next fit: scan from the hint, wrap to zero, stay below the length
        p = (alloc_hint < eff_len) ? alloc_hint : 0;
        r.result_pos = '0;
        found = 1'b0;
        for (i = 0; i < eff_len && !found; i++) begin
          if (!used_bits[p]) begin
            r.result_pos = PosW'(p);
            r.hit = 1'b1;
            found = 1'b1;
          end else begin
            p++;
            if (p >= eff_len) p = 0;
          end
        end
      end
      CMD_SET: begin
        if (in_range && !used_bits[w.position]) begin
          used_bits[w.position] = 1'b1;
          used_total++;
          alloc_hint = (w.position + 1 >= eff_len) ? '0 : PosW'(w.position + 1);
          r.hit = 1'b1;
        end
      end
      default: begin
        if (in_range && used_bits[w.position]) begin
          used_bits[w.position] = 1'b0;
          used_total--;
          r.hit = 1'b1;
        end
      end
    endcase
    r.all_used = (used_total >= eff_len);
    r.used_count = used_total;
    return r;
  endfunction

  // Watch the channels: check results first, then log config and commands
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      used_bits  = '0;
      alloc_hint = '0;
      used_total = '0;
      length_reg = LenReset;
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word, result_pos", out_data_i.result_pos, -1);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.result_pos !== want.result_pos)
            report_mismatch("result_pos", out_data_i.result_pos, want.result_pos);
          if (out_data_i.hit !== want.hit)
            report_mismatch("hit", out_data_i.hit, want.hit);
          if (out_data_i.all_used !== want.all_used)
            report_mismatch("all_used", out_data_i.all_used, want.all_used);
          if (out_data_i.used_count !== want.used_count)
            report_mismatch("used_count", out_data_i.used_count, want.used_count);
        end
        words_checked_o++;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        length_reg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(alloc_outcome(in_data_i));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/tb_bitmap_id_allocator_next_fit.sv */
`timescale 1ns / 1ps
module tb_bitmap_id_allocator_next_fit;
  import bmalloc_pkg::*;

  localparam int CycleLimit    = 1000000;
  localparam int NumPhases     = 14;
  localparam int ItemsPerPhase = 138;
  localparam int MaxGap        = 18;
  localparam int HoldCycles    = 300;
  localparam int SettleCycles  = 40;

  logic            clk_i;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_word_t        in_data   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_word_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [LenW-1:0] cfg_data  = '0;

  int              fail_count;
  int              pending;
  int              words_checked;
  int              cycle_count = 0;
  int              commands_sent = 0;
  int              length_writes = 0;
  bit              no_idle = 1'b0;
  bit              hold_req = 1'b0;

  // Per-phase length, sequential-allocation mode, burst mode, long output hold
  int unsigned     phase_len  [0:NumPhases-1] =
    '{40, 1, 2, 33, 64, 1024, 7, 0, 100, 2047, 32, 1025, 500, 1023};
  bit              phase_seq  [0:NumPhases-1] =
    '{0, 0, 0, 1, 1, 1, 0, 0, 1, 1, 0, 1, 1, 1};
  bit              phase_burst[0:NumPhases-1] =
    '{0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 0};
  bit              phase_hold [0:NumPhases-1] =
    '{0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  bitmap_id_allocator_next_fit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  bitmap_alloc_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Reset once, at the start
  initial begin
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles, %0d results still due", cycle_count, pending);
    $display("Test completed with failures");
    $finish;
  end

  // Drain the output: random stall before each word (none in burst mode), one long hold on request
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        gap = HoldCycles;
        hold_req = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, MaxGap);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  // Offer one command word after a random gap (none in burst mode) and hold it until taken
  task automatic send_command(input logic [1:0] cmd, input int unsigned pos);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data.cmd <= cmd;
    in_data.position <= PosW'(pos);
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    commands_sent++;
  endtask

  // Stop offering and wait until every result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // Write the managed length once the block has gone quiet
  task automatic write_length(input int unsigned len);
    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= LenW'(len);
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    length_writes++;
  endtask

  // Stimulus and verdict
  initial begin
    int unsigned eff_len;
    int unsigned cursor;
    int unsigned roll;
    int unsigned pos;
    logic [1:0]  cmd;
    wait (rst_n);
    @(posedge clk_i);

    // Directed: reset length, wrap of the hint, repeated set and clear
    send_command(CMD_GET, 0);
    send_command(CMD_TEST, 0);
    send_command(CMD_TEST, 1023);
    send_command(CMD_SET, 1023);
    send_command(CMD_SET, 0);
    send_command(CMD_GET, 1023);
    send_command(CMD_CLEAR, 0);
    send_command(CMD_CLEAR, 0);
    send_command(CMD_SET, 1023);
    send_command(CMD_SET, 900);

    // Hint beyond a lowered length, bits stranded above it
    write_length(16);
    send_command(CMD_GET, 0);
    send_command(CMD_TEST, 900);
    send_command(CMD_CLEAR, 900);

    // Zero length: nothing in range, always full
    write_length(0);
    send_command(CMD_GET, 0);
    send_command(CMD_SET, 5);
    send_command(CMD_TEST, 5);

    // Oversized length saturates at the map size
    write_length(2047);
    send_command(CMD_CLEAR, 900);
    send_command(CMD_CLEAR, 1023);
    send_command(CMD_TEST, 1023);

    // Single position: fill it, find nothing, out of range set
    write_length(1);
    send_command(CMD_SET, 0);
    send_command(CMD_GET, 0);
    send_command(CMD_SET, 1);
    send_command(CMD_CLEAR, 0);

    // Random phases over a range of lengths
    for (int k = 0; k < NumPhases; k++) begin
      write_length(phase_len[k]);
      no_idle = phase_burst[k];
      hold_req = phase_hold[k];
      eff_len = (phase_len[k] > MaxPositions) ? MaxPositions : phase_len[k];
      cursor = (eff_len == 0) ? 0 : $urandom_range(0, eff_len - 1);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) cmd = CMD_SET;
        else if (roll < 65) cmd = CMD_GET;
        else if (roll < 85) cmd = CMD_CLEAR;
        else cmd = CMD_TEST;
        // Mostly in-range positions; in sequential mode runs of consecutive positions build full words
        roll = $urandom_range(0, 99);
        if (roll < 10 || eff_len == 0) begin
          pos = $urandom_range(0, MaxPositions - 1);
        end else if (phase_seq[k] && roll < 60) begin
          pos = cursor;
          cursor = (cursor + 1) % eff_len;
        end else begin
          pos = $urandom_range(0, eff_len);
          if (pos > MaxPositions - 1) pos = MaxPositions - 1;
        end
        send_command(cmd, pos);
      end
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (2 * SettleCycles) @(posedge clk_i);

    $display("Sent %0d commands (test, get, set, clear) across %0d length writes,",
             commands_sent, length_writes);
    $display("checked %0d result words with %0d mismatches", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/bmalloc_pkg.sv
src/bmalloc_map.sv
src/bmalloc_scan.sv
src/bitmap_id_allocator_next_fit.sv
tb/bitmap_alloc_checker.sv
tb/tb_bitmap_id_allocator_next_fit.sv
